[sv/lli_pkg.sv]
// Shared constants, status codes and handshake types for the line intersection block.
`timescale 1ns / 1ps

package lli_pkg;

    // Register and result widths fixed by the block definition
    localparam int THRESH_BITS = 34;
    localparam int POINT_BITS  = 32;

    // Saturation limits of a Q24.8 result
    localparam logic [POINT_BITS-1:0] POINT_MAX = 32'h7FFF_FFFF;
    localparam logic [POINT_BITS-1:0] POINT_MIN = 32'h8000_0000;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_PARALLEL  = 2'd1,
        ST_SATURATED = 2'd2
    } lli_status_t;

    // Fill state reported by the queue
    typedef struct packed {
        logic full;
        logic empty;
    } lli_q_status_t;

endpackage

[sv/lli_front.sv]
// Front pipeline: determinant, cross products, numerators and parallel check.
`timescale 1ns / 1ps

module lli_front
    import lli_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  a1_x,
    input  logic signed [COORD_BITS-1:0]  a1_y,
    input  logic signed [COORD_BITS-1:0]  a2_x,
    input  logic signed [COORD_BITS-1:0]  a2_y,
    input  logic signed [COORD_BITS-1:0]  b1_x,
    input  logic signed [COORD_BITS-1:0]  b1_y,
    input  logic signed [COORD_BITS-1:0]  b2_x,
    input  logic signed [COORD_BITS-1:0]  b2_y,
    input  logic [THRESH_BITS-1:0]        thr,
    input  lli_q_status_t                 q_status,
    output logic                          out_valid,
    output logic [2*(3*COORD_BITS+3)+(2*COORD_BITS+3):0] out_data
);

    localparam int C   = COORD_BITS;
    localparam int DFW = C + 1;         // coordinate difference
    localparam int PW  = 2 * C + 2;     // product of two differences
    localparam int CPW = 2 * C;         // product of two coordinates
    localparam int CW  = 2 * C + 1;     // endpoint cross product
    localparam int DW  = 2 * C + 3;     // determinant
    localparam int MW  = 3 * C + 2;     // numerator partial product
    localparam int NW  = 3 * C + 3;     // numerator
    localparam int TCW = (DW > THRESH_BITS) ? DW : THRESH_BITS;

    logic en;

    // Stage 1: coordinates and differences
    logic                   v1_reg;
    logic signed [C-1:0]    a1x_reg, a1y_reg, a2x_reg, a2y_reg;
    logic signed [C-1:0]    b1x_reg, b1y_reg, b2x_reg, b2y_reg;
    logic signed [DFW-1:0]  dax1_reg, day1_reg, dbx1_reg, dby1_reg;

    // Stage 2: six products
    logic                   v2_reg;
    logic signed [PW-1:0]   pd1_reg, pd2_reg;
    logic signed [CPW-1:0]  pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic signed [DFW-1:0]  dax2_reg, day2_reg, dbx2_reg, dby2_reg;

    // Stage 3: determinant and cross products
    logic                   v3_reg;
    logic signed [DW-1:0]   den3_reg;
    logic signed [CW-1:0]   ca3_reg, cb3_reg;
    logic signed [DFW-1:0]  dax3_reg, day3_reg, dbx3_reg, dby3_reg;

    // Stage 4: numerator products and parallel flag
    logic                   v4_reg;
    logic signed [DW-1:0]   den4_reg;
    logic                   par4_reg;
    logic signed [MW-1:0]   m1_reg, m2_reg, m3_reg, m4_reg;

    // Stage 5: numerators
    logic                   v5_reg;
    logic signed [DW-1:0]   den5_reg;
    logic                   par5_reg;
    logic signed [NW-1:0]   nx5_reg, ny5_reg;

    logic [DW-1:0]          den_mag;
    logic                   par_next;

    // Advance unless the last stage holds an item the queue cannot take
    assign en       = !v5_reg || !q_status.full;
    assign in_ready = en;

    // Classify near-zero determinants as parallel
    always_comb
    begin
        den_mag  = den3_reg[DW-1] ? (~den3_reg + DW'(1)) : den3_reg;
        par_next = (den_mag == '0) || (TCW'(den_mag) < TCW'(thr));
    end

    // Hold stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1x_reg  <= a1_x;
            a1y_reg  <= a1_y;
            a2x_reg  <= a2_x;
            a2y_reg  <= a2_y;
            b1x_reg  <= b1_x;
            b1y_reg  <= b1_y;
            b2x_reg  <= b2_x;
            b2y_reg  <= b2_y;
            dax1_reg <= DFW'(a1_x) - DFW'(a2_x);
            day1_reg <= DFW'(a1_y) - DFW'(a2_y);
            dbx1_reg <= DFW'(b1_x) - DFW'(b2_x);
            dby1_reg <= DFW'(b1_y) - DFW'(b2_y);

            pd1_reg  <= PW'(dby1_reg) * PW'(dax1_reg);
            pd2_reg  <= PW'(day1_reg) * PW'(dbx1_reg);
            pa1_reg  <= CPW'(a1x_reg) * CPW'(a2y_reg);
            pa2_reg  <= CPW'(a2x_reg) * CPW'(a1y_reg);
            pb1_reg  <= CPW'(b1x_reg) * CPW'(b2y_reg);
            pb2_reg  <= CPW'(b2x_reg) * CPW'(b1y_reg);
            dax2_reg <= dax1_reg;
            day2_reg <= day1_reg;
            dbx2_reg <= dbx1_reg;
            dby2_reg <= dby1_reg;

            den3_reg <= DW'(pd1_reg) - DW'(pd2_reg);
            ca3_reg  <= CW'(pa1_reg) - CW'(pa2_reg);
            cb3_reg  <= CW'(pb1_reg) - CW'(pb2_reg);
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            dbx3_reg <= dbx2_reg;
            dby3_reg <= dby2_reg;

            den4_reg <= den3_reg;
            par4_reg <= par_next;
            m1_reg   <= MW'(ca3_reg) * MW'(dbx3_reg);
            m2_reg   <= MW'(cb3_reg) * MW'(dax3_reg);
            m3_reg   <= MW'(dby3_reg) * MW'(ca3_reg);
            m4_reg   <= MW'(day3_reg) * MW'(cb3_reg);

            den5_reg <= den4_reg;
            par5_reg <= par4_reg;
            nx5_reg  <= NW'(m1_reg) - NW'(m2_reg);
            ny5_reg  <= NW'(m3_reg) - NW'(m4_reg);
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = {par5_reg, den5_reg, ny5_reg, nx5_reg};

endmodule

[sv/lli_queue.sv]
// Short FIFO that decouples the front pipeline from the divider back end.
`timescale 1ns / 1ps

module lli_queue
    import lli_pkg::*;
#(
    parameter int WIDTH = 118
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output lli_q_status_t    status
);

    logic [WIDTH-1:0]        mem_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_BITS:0] wr_ptr_reg, rd_ptr_reg;
    logic                    do_push, do_pop;

    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.full  = ((wr_ptr_reg - rd_ptr_reg) == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg[QUEUE_PTR_BITS-1:0]];

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the item at the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[QUEUE_PTR_BITS-1:0]] <= push_data;
        end
    end

endmodule

[sv/lli_back.sv]
// Back end: pipelined restoring dividers for x and y, saturation and output register.
`timescale 1ns / 1ps

module lli_back
    import lli_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lli_q_status_t         q_status,
    input  logic [2*(3*COORD_BITS+3)+(2*COORD_BITS+3):0] q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POINT_BITS-1:0] point_x,
    output logic [POINT_BITS-1:0] point_y,
    output logic [1:0]            status
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;
    localparam int NW = 3 * C + 3;
    localparam int QW = 2 * NW + DW + 1;
    localparam int RW = (NW > DW + POINT_BITS) ? NW : DW + POINT_BITS;
    localparam int QB = POINT_BITS;

    logic en;

    // Queue head fields
    logic [NW-1:0] nx_in, ny_in, nx_mag, ny_mag;
    logic [DW-1:0] den_in, den_mag;
    logic          par_in;

    // Divider stages; index 0 is the magnitude stage
    logic              v_reg   [0:QB];
    logic [RW-1:0]     rx_reg  [0:QB];
    logic [RW-1:0]     ry_reg  [0:QB];
    logic [QB-1:0]     qx_reg  [0:QB];
    logic [QB-1:0]     qy_reg  [0:QB];
    logic [DW-1:0]     dm_reg  [0:QB];
    logic              sx_reg  [0:QB];
    logic              sy_reg  [0:QB];
    logic              par_reg [0:QB];
    logic              ovx_reg [1:QB];
    logic              ovy_reg [1:QB];

    logic [RW-1:0]     dsh     [0:QB-1];
    logic [RW-1:0]     rx_n    [0:QB-1];
    logic [RW-1:0]     ry_n    [0:QB-1];
    logic [QB-1:0]     qx_n    [0:QB-1];
    logic [QB-1:0]     qy_n    [0:QB-1];
    logic              ovx_n, ovy_n;

    // Output register
    logic              out_valid_reg;
    logic [QB-1:0]     px_reg, py_reg;
    lli_status_t       status_reg;

    logic [QB-1:0]     px_next, py_next;
    logic              xsat, ysat;
    lli_status_t       status_next;

    // Stall the whole back end while a result waits
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_status.empty;

    // Unpack the queue head and take magnitudes
    always_comb
    begin
        nx_in   = q_data[NW-1:0];
        ny_in   = q_data[2*NW-1:NW];
        den_in  = q_data[2*NW+DW-1:2*NW];
        par_in  = q_data[QW-1];
        nx_mag  = nx_in[NW-1] ? (~nx_in + NW'(1)) : nx_in;
        ny_mag  = ny_in[NW-1] ? (~ny_in + NW'(1)) : ny_in;
        den_mag = den_in[DW-1] ? (~den_in + DW'(1)) : den_in;
    end

    // One quotient bit per stage, most significant first
    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            dsh[k] = RW'(dm_reg[k]) << (QB - 1 - k);
            if (rx_reg[k] >= dsh[k])
            begin
                rx_n[k] = rx_reg[k] - dsh[k];
                qx_n[k] = qx_reg[k] | (QB'(1) << (QB - 1 - k));
            end
            else
            begin
                rx_n[k] = rx_reg[k];
                qx_n[k] = qx_reg[k];
            end
            if (ry_reg[k] >= dsh[k])
            begin
                ry_n[k] = ry_reg[k] - dsh[k];
                qy_n[k] = qy_reg[k] | (QB'(1) << (QB - 1 - k));
            end
            else
            begin
                ry_n[k] = ry_reg[k];
                qy_n[k] = qy_reg[k];
            end
        end
        // Quotient does not fit in 32 bits at all
        ovx_n = rx_reg[0] >= (RW'(dm_reg[0]) << QB);
        ovy_n = ry_reg[0] >= (RW'(dm_reg[0]) << QB);
    end

    // Apply sign and clamp
    always_comb
    begin
        xsat = ovx_reg[QB] || (sx_reg[QB] ? (qx_reg[QB] > POINT_MIN) : qx_reg[QB][QB-1]);
        ysat = ovy_reg[QB] || (sy_reg[QB] ? (qy_reg[QB] > POINT_MIN) : qy_reg[QB][QB-1]);
        if (par_reg[QB])
        begin
            px_next     = '0;
            py_next     = '0;
            status_next = ST_PARALLEL;
        end
        else
        begin
            if (xsat)
            begin
                px_next = sx_reg[QB] ? POINT_MIN : POINT_MAX;
            end
            else
            begin
                px_next = sx_reg[QB] ? (~qx_reg[QB] + QB'(1)) : qx_reg[QB];
            end
            if (ysat)
            begin
                py_next = sy_reg[QB] ? POINT_MIN : POINT_MAX;
            end
            else
            begin
                py_next = sy_reg[QB] ? (~qy_reg[QB] + QB'(1)) : qy_reg[QB];
            end
            status_next = (xsat || ysat) ? ST_SATURATED : ST_FOUND;
        end
    end

    // Hold valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= !q_status.empty;
            for (int k = 0; k < QB; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            out_valid_reg <= v_reg[QB];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]  <= RW'(nx_mag);
            ry_reg[0]  <= RW'(ny_mag);
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            dm_reg[0]  <= den_mag;
            sx_reg[0]  <= nx_in[NW-1] ^ den_in[DW-1];
            sy_reg[0]  <= ny_in[NW-1] ^ den_in[DW-1];
            par_reg[0] <= par_in;
            for (int k = 0; k < QB; k++)
            begin
                rx_reg[k+1]  <= rx_n[k];
                ry_reg[k+1]  <= ry_n[k];
                qx_reg[k+1]  <= qx_n[k];
                qy_reg[k+1]  <= qy_n[k];
                dm_reg[k+1]  <= dm_reg[k];
                sx_reg[k+1]  <= sx_reg[k];
                sy_reg[k+1]  <= sy_reg[k];
                par_reg[k+1] <= par_reg[k];
            end
            ovx_reg[1] <= ovx_n;
            ovy_reg[1] <= ovy_n;
            for (int k = 1; k < QB; k++)
            begin
                ovx_reg[k+1] <= ovx_reg[k];
                ovy_reg[k+1] <= ovy_reg[k];
            end
            px_reg     <= px_next;
            py_reg     <= py_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign status    = status_reg;

endmodule

[sv/line_line_intersection.sv]
// Top level of the two-line intersection block: ports, threshold register, front, queue, back.
//
//  channel  | signals                       | direction | content
//  ---------+-------------------------------+-----------+---------------------------------
//  s_*      | s_tvalid s_tready s_tdata     | in        | a1/a2/b1/b2 endpoints, Q8.8
//  m_*      | m_tvalid m_tready m_tdata     | out       | intersection point, Q24.8
//           | m_tuser                       |           | status code
//  cfg_*    | cfg_valid cfg_ready cfg_data  | in        | parallel threshold, 2^-16 units
//
//  One item per cycle sustained while m_tready is high; the 32-stage restoring divider
//  (one quotient bit per stage) sits behind a 5-stage multiply pipeline.
//  Reset sets the threshold to 1 and empties the pipelines and the 4-entry queue.
//  While a result waits with m_tready low the divider pipeline holds; the front keeps
//  taking items until it and the queue fill, then s_tready drops. cfg_ready is always high.
`timescale 1ns / 1ps

module line_line_intersection
    import lli_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y (COORD_BITS each)
    input  logic [8*COORD_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // point_x [31:0], point_y [63:32]
    output logic [2*POINT_BITS-1:0]   m_tdata,
    // status [1:0]
    output logic [1:0]                m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [THRESH_BITS-1:0]    cfg_data
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;
    localparam int NW = 3 * C + 3;
    localparam int QW = 2 * NW + DW + 1;

    logic [THRESH_BITS-1:0] thr_reg;

    logic signed [C-1:0] a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y;
    logic                front_valid;
    logic [QW-1:0]       front_data;
    logic [QW-1:0]       head_data;
    logic                pop;
    lli_q_status_t       q_status;
    logic [POINT_BITS-1:0] point_x, point_y;

    // Unpack the input item
    assign a1_x = s_tdata[0*C +: C];
    assign a1_y = s_tdata[1*C +: C];
    assign a2_x = s_tdata[2*C +: C];
    assign a2_y = s_tdata[3*C +: C];
    assign b1_x = s_tdata[4*C +: C];
    assign b1_y = s_tdata[5*C +: C];
    assign b2_x = s_tdata[6*C +: C];
    assign b2_y = s_tdata[7*C +: C];

    // Hold the parallel threshold
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    lli_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a1_x      (a1_x),
        .a1_y      (a1_y),
        .a2_x      (a2_x),
        .a2_y      (a2_y),
        .b1_x      (b1_x),
        .b1_y      (b1_y),
        .b2_x      (b2_x),
        .b2_y      (b2_y),
        .thr       (thr_reg),
        .q_status  (q_status),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    lli_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_data),
        .pop       (pop),
        .pop_data  (head_data),
        .status    (q_status)
    );

    lli_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (head_data),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .point_x   (point_x),
        .point_y   (point_y),
        .status    (m_tuser)
    );

    assign m_tdata = {point_y, point_x};

endmodule
